/* sv/fre_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_pkg
// Shared types, widths, register indexes and reset values of the flow rate
// estimator.
// ----------------------------------------------------------------------------
package fre_pkg;

    // field widths
    localparam int RATE_W   = 20;
    localparam int WEIGHT_W = 24;
    localparam int REL_W    = WEIGHT_W + 1;
    localparam int DELTA_W  = REL_W + 1;
    localparam int MAG_W    = REL_W;
    localparam int TS_W     = 32;
    localparam int ALPHA_W  = 8;
    localparam int IVL_W    = 24;
    localparam int CNT_W    = 8;
    localparam int SCALE_W  = 20;
    localparam int NUM_W    = MAG_W + SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // default fraction bits of the filtered rate
    localparam int RATE_FRACTION_BITS_DEF = 8;

    // microseconds per second, the rate scale factor
    localparam logic [SCALE_W-1:0] US_PER_SEC = SCALE_W'(1000000);

    // saturation point of the no-flow counter
    localparam logic [CNT_W-1:0] NO_FLOW_SAT = CNT_W'(255);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARE_WEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RISE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FALL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID_RATE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_EPSILON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_US = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL_US = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLOW_LIMIT   = 3'd7;

    // register reset values
    localparam logic [WEIGHT_W-1:0] TARE_WEIGHT_RST     = '0;
    localparam logic [ALPHA_W-1:0]  ALPHA_RISE_RST      = ALPHA_W'(46);
    localparam logic [ALPHA_W-1:0]  ALPHA_FALL_RST      = ALPHA_W'(141);
    localparam logic [RATE_W-1:0]   MIN_VALID_RATE_RST  = RATE_W'(200);
    localparam logic [RATE_W-1:0]   ZERO_EPSILON_RST    = RATE_W'(50);
    localparam logic [IVL_W-1:0]    MIN_INTERVAL_US_RST = IVL_W'(50000);
    localparam logic [IVL_W-1:0]    MAX_INTERVAL_US_RST = IVL_W'(800000);
    localparam logic [CNT_W-1:0]    NO_FLOW_LIMIT_RST   = CNT_W'(2);

    // command codes
    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [WEIGHT_W-1:0] weight;
        logic [TS_W-1:0]            timestamp_us;
    } sample_t;

    typedef struct packed {
        logic [RATE_W-1:0] raw_rate;
        logic [RATE_W-1:0] filtered_rate;
    } result_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] tare_weight;
        logic [ALPHA_W-1:0]         alpha_rise;
        logic [ALPHA_W-1:0]         alpha_fall;
        logic [RATE_W-1:0]          min_valid_rate;
        logic [RATE_W-1:0]          zero_epsilon;
        logic [IVL_W-1:0]           min_interval_us;
        logic [IVL_W-1:0]           max_interval_us;
        logic [CNT_W-1:0]           no_flow_limit;
    } cfg_t;

endpackage

/* sv/fre_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_regs
// Configuration register bank, written one register per beat.
// ----------------------------------------------------------------------------
module fre_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fre_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fre_pkg::cfg_t                     cfg
);

    fre_pkg::cfg_t cfg_reg;

    // writes are taken in any cycle
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tare_weight     <= fre_pkg::TARE_WEIGHT_RST;
            cfg_reg.alpha_rise      <= fre_pkg::ALPHA_RISE_RST;
            cfg_reg.alpha_fall      <= fre_pkg::ALPHA_FALL_RST;
            cfg_reg.min_valid_rate  <= fre_pkg::MIN_VALID_RATE_RST;
            cfg_reg.zero_epsilon    <= fre_pkg::ZERO_EPSILON_RST;
            cfg_reg.min_interval_us <= fre_pkg::MIN_INTERVAL_US_RST;
            cfg_reg.max_interval_us <= fre_pkg::MAX_INTERVAL_US_RST;
            cfg_reg.no_flow_limit   <= fre_pkg::NO_FLOW_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fre_pkg::REG_TARE_WEIGHT:
                    cfg_reg.tare_weight <= cfg_data[fre_pkg::WEIGHT_W-1:0];
                fre_pkg::REG_ALPHA_RISE:
                    cfg_reg.alpha_rise <= cfg_data[fre_pkg::ALPHA_W-1:0];
                fre_pkg::REG_ALPHA_FALL:
                    cfg_reg.alpha_fall <= cfg_data[fre_pkg::ALPHA_W-1:0];
                fre_pkg::REG_MIN_VALID_RATE:
                    cfg_reg.min_valid_rate <= cfg_data[fre_pkg::RATE_W-1:0];
                fre_pkg::REG_ZERO_EPSILON:
                    cfg_reg.zero_epsilon <= cfg_data[fre_pkg::RATE_W-1:0];
                fre_pkg::REG_MIN_INTERVAL_US:
                    cfg_reg.min_interval_us <= cfg_data[fre_pkg::IVL_W-1:0];
                fre_pkg::REG_MAX_INTERVAL_US:
                    cfg_reg.max_interval_us <= cfg_data[fre_pkg::IVL_W-1:0];
                fre_pkg::REG_NO_FLOW_LIMIT:
                    cfg_reg.no_flow_limit <= cfg_data[fre_pkg::CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* sv/fre_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fre_divider
// Restoring divider, one quotient bit per cycle, with the quotient saturated
// to the rate range. A zero divisor saturates.
// ----------------------------------------------------------------------------
module fre_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [fre_pkg::NUM_W-1:0]       numerator,
    input  logic [fre_pkg::TS_W-1:0]        divisor,
    output logic                            done,
    output logic [fre_pkg::RATE_W-1:0]      quotient
);

    localparam int RATE_W = fre_pkg::RATE_W;
    localparam int TS_W   = fre_pkg::TS_W;
    localparam int NUM_W  = fre_pkg::NUM_W;
    localparam int STEP_W = $clog2(RATE_W + 1);
    localparam int WIDE_W = TS_W + RATE_W;

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  count_reg;
    logic [TS_W-1:0]    rem_reg;
    logic [TS_W-1:0]    divisor_reg;
    logic [RATE_W-1:0]  low_reg;
    logic [RATE_W-1:0]  quo_reg;

    logic [TS_W:0]      shifted;
    logic [TS_W:0]      trial;
    logic               overflow;

    // quotient would not fit the rate range
    assign overflow = WIDE_W'(numerator) >= {divisor, {RATE_W{1'b0}}};

    // one trial subtraction per cycle
    assign shifted = {rem_reg, low_reg[RATE_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (overflow)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg  <= 1'b1;
                    count_reg <= STEP_W'(RATE_W);
                end
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= TS_W'(numerator[NUM_W-1:RATE_W]);
            low_reg     <= numerator[RATE_W-1:0];
            quo_reg     <= overflow ? {RATE_W{1'b1}} : '0;
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[RATE_W-2:0], 1'b0};
            if (!trial[TS_W])
            begin
                rem_reg <= trial[TS_W-1:0];
                quo_reg <= {quo_reg[RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[TS_W-1:0];
                quo_reg <= {quo_reg[RATE_W-2:0], 1'b0};
            end
        end
    end

endmodule

/* sv/flow_rate_estimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_rate_estimator
// Scale flow rate estimator: tare, weight change over elapsed time through an
// iterative divider, asymmetric EWMA filter with no-flow forcing.
// ----------------------------------------------------------------------------
// a restart or first sample runs PREP then DONE; a sample outside the interval
// window runs PREP, CHECK, DONE; one with no weight gain runs PREP, CHECK, MUL,
// FILT1, FILT2, SNAP, DONE; a gain adds DIVGO and DIVWAIT on the 20-step bit-serial
// divider, which skips its steps when the rate saturates. A held result
// beat keeps an item in DONE; sample_stall is high while an item is worked on.
// reset clears all state and loads register defaults.
module flow_rate_estimator #(
    parameter int RATE_FRACTION_BITS = fre_pkg::RATE_FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  fre_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output fre_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fre_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RATE_W   = fre_pkg::RATE_W;
    localparam int WEIGHT_W = fre_pkg::WEIGHT_W;
    localparam int REL_W    = fre_pkg::REL_W;
    localparam int DELTA_W  = fre_pkg::DELTA_W;
    localparam int MAG_W    = fre_pkg::MAG_W;
    localparam int TS_W     = fre_pkg::TS_W;
    localparam int ALPHA_W  = fre_pkg::ALPHA_W;
    localparam int CNT_W    = fre_pkg::CNT_W;
    localparam int NUM_W    = fre_pkg::NUM_W;
    localparam int FINE_W   = RATE_W + RATE_FRACTION_BITS;
    localparam int PROD_W   = FINE_W + ALPHA_W + 2;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PREP    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd3;
    localparam logic [3:0] S_DIVGO   = 4'd4;
    localparam logic [3:0] S_DIVWAIT = 4'd5;
    localparam logic [3:0] S_FILT1   = 4'd6;
    localparam logic [3:0] S_FILT2   = 4'd7;
    localparam logic [3:0] S_SNAP    = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    fre_pkg::cfg_t              cfg;

    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;

    // item registers
    logic                       cmd_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic [TS_W-1:0]            ts_reg;
    logic signed [REL_W-1:0]    rel_reg;
    logic [TS_W-1:0]            dt_reg;
    logic                       delta_pos_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [RATE_W-1:0]          raw_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [FINE_W-1:0]          sample_fine_reg;
    logic                       force_zero_reg;
    logic                       seed_reg;

    // filter state
    logic signed [REL_W-1:0]    prev_weight_reg;
    logic [TS_W-1:0]            prev_time_reg;
    logic                       have_prev_reg;
    logic [CNT_W-1:0]           nf_count_reg;
    logic [RATE_W-1:0]          raw_hold_reg;
    logic [FINE_W-1:0]          fine_reg;

    // output register
    logic                       result_valid_reg;
    fre_pkg::result_t           result_reg;

    // combinational values
    logic                       in_accept;
    logic                       out_free;
    logic signed [REL_W-1:0]    rel;
    logic signed [DELTA_W-1:0]  delta;
    logic                       in_window;
    logic [NUM_W-1:0]           num_prod;
    logic                       div_start;
    logic                       div_done;
    logic [RATE_W-1:0]          div_quo;
    logic [RATE_W-1:0]          raw_valid;
    logic [CNT_W-1:0]           cnt_inc;
    logic [FINE_W-1:0]          sample_fine;
    logic [ALPHA_W-1:0]         alpha_sel;
    logic signed [ALPHA_W:0]    alpha_ext;
    logic signed [FINE_W:0]     diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   step;
    logic [FINE_W+1:0]          ewma_sum;
    logic [FINE_W-1:0]          ewma_res;
    logic [FINE_W-1:0]          eps_fine;

    fre_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fre_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (num_reg),
        .divisor   (dt_reg),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // handshakes
    assign sample_stall = (state_reg != S_IDLE);
    assign in_accept    = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign div_start    = (state_reg == S_DIVGO);

    // tare, weight change, interval window
    assign rel       = REL_W'(weight_reg) - REL_W'(cfg.tare_weight);
    assign delta     = DELTA_W'(rel_reg) - DELTA_W'(prev_weight_reg);
    assign in_window = (dt_reg >= TS_W'(cfg.min_interval_us))
                    && (dt_reg <= TS_W'(cfg.max_interval_us));
    assign num_prod  = NUM_W'(mag_reg) * NUM_W'(fre_pkg::US_PER_SEC);

    // raw rate floor and filter gain selection
    assign raw_valid   = (raw_reg < cfg.min_valid_rate) ? '0 : raw_reg;
    assign cnt_inc     = (nf_count_reg == fre_pkg::NO_FLOW_SAT)
                       ? nf_count_reg : nf_count_reg + 1'b1;
    assign sample_fine = {raw_valid, {RATE_FRACTION_BITS{1'b0}}};
    assign alpha_sel   = ((raw_valid != '0) && (sample_fine >= fine_reg))
                       ? cfg.alpha_rise : cfg.alpha_fall;
    assign alpha_ext   = {1'b0, alpha_sel};
    assign diff        = $signed({1'b0, sample_fine}) - $signed({1'b0, fine_reg});
    assign prod        = alpha_ext * diff;

    // filter update with floor division by 256 and clamping
    assign step     = prod_reg >>> ALPHA_W;
    assign ewma_sum = {2'b00, fine_reg} + step[FINE_W+1:0];
    always_comb
    begin
        if (ewma_sum[FINE_W+1])
            ewma_res = '0;
        else if (ewma_sum[FINE_W])
            ewma_res = {FINE_W{1'b1}};
        else
            ewma_res = ewma_sum[FINE_W-1:0];
    end

    assign eps_fine = {cfg.zero_epsilon, {RATE_FRACTION_BITS{1'b0}}};

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_accept)
                    state_next = S_PREP;
            S_PREP:
                if (cmd_reg == fre_pkg::CMD_RESTART || !have_prev_reg)
                    state_next = S_DONE;
                else
                    state_next = S_CHECK;
            S_CHECK:
                state_next = in_window ? S_MUL : S_DONE;
            S_MUL:
                state_next = delta_pos_reg ? S_DIVGO : S_FILT1;
            S_DIVGO:
                state_next = S_DIVWAIT;
            S_DIVWAIT:
                if (div_done)
                    state_next = S_FILT1;
            S_FILT1:
                state_next = S_FILT2;
            S_FILT2:
                state_next = S_SNAP;
            S_SNAP:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_weight_reg  <= '0;
            prev_time_reg    <= '0;
            have_prev_reg    <= 1'b0;
            nf_count_reg     <= '0;
            raw_hold_reg     <= '0;
            fine_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (result_valid_reg && !result_stall && state_reg != S_DONE)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_PREP:
                    if (cmd_reg == fre_pkg::CMD_RESTART)
                    begin
                        prev_weight_reg <= '0;
                        prev_time_reg   <= '0;
                        have_prev_reg   <= 1'b0;
                        nf_count_reg    <= '0;
                        raw_hold_reg    <= '0;
                        fine_reg        <= '0;
                    end
                    else if (!have_prev_reg)
                    begin
                        prev_weight_reg <= rel;
                        prev_time_reg   <= ts_reg;
                        have_prev_reg   <= 1'b1;
                    end
                S_CHECK:
                begin
                    prev_weight_reg <= rel_reg;
                    prev_time_reg   <= ts_reg;
                end
                S_FILT1:
                begin
                    raw_hold_reg <= raw_valid;
                    nf_count_reg <= (raw_valid == '0) ? cnt_inc : '0;
                end
                S_FILT2:
                    if (force_zero_reg)
                        fine_reg <= '0;
                    else if (seed_reg)
                        fine_reg <= sample_fine_reg;
                    else
                        fine_reg <= ewma_res;
                S_SNAP:
                    if (fine_reg < eps_fine)
                        fine_reg <= '0;
                S_DONE:
                    if (out_free)
                        result_valid_reg <= 1'b1;
                default:
                    fine_reg <= fine_reg;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= sample.command;
            weight_reg <= sample.weight;
            ts_reg     <= sample.timestamp_us;
        end

        case (state_reg)
            S_PREP:
            begin
                rel_reg <= rel;
                dt_reg  <= ts_reg - prev_time_reg;
            end
            S_CHECK:
            begin
                delta_pos_reg <= !delta[DELTA_W-1] && (delta != '0);
                mag_reg       <= delta[MAG_W-1:0];
            end
            S_MUL:
            begin
                num_reg <= num_prod;
                raw_reg <= '0;
            end
            S_DIVWAIT:
                if (div_done)
                    raw_reg <= div_quo;
            S_FILT1:
            begin
                prod_reg        <= prod;
                sample_fine_reg <= sample_fine;
                seed_reg        <= (fine_reg == '0);
                force_zero_reg  <= (raw_valid == '0) && (cnt_inc >= cfg.no_flow_limit);
            end
            S_DONE:
                if (out_free)
                begin
                    result_reg.raw_rate      <= raw_hold_reg;
                    result_reg.filtered_rate <= fine_reg[FINE_W-1:RATE_FRACTION_BITS];
                end
            default:
                ;
        endcase
    end

`ifndef SYNTHESIS
    // a restart leaves the filter empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP && cmd_reg == fre_pkg::CMD_RESTART) |=>
        (fine_reg == '0 && !have_prev_reg && raw_hold_reg == '0))
        else $error("restart did not clear filter state");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVWAIT))
        else $error("divider done outside wait state");

    // a running no-flow count means the last raw rate was zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (nf_count_reg != '0) |-> (raw_hold_reg == '0))
        else $error("no-flow count with nonzero raw rate");

    // leaving the done state always loads a result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> result_valid_reg)
        else $error("result beat not loaded");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow rate estimator. A predictor in the bench
// tracks tare, sample spacing, raw rate, no-flow count and the asymmetric EWMA
// at full fixed point, and every result beat is compared with it. Stimulus is
// a directed pass over defaults and register extremes, then randomized pour
// sequences under several register settings, random idling on both sides and
// one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     RATE_W      = fre_pkg::RATE_W;
    localparam int     WEIGHT_W    = fre_pkg::WEIGHT_W;
    localparam int     ALPHA_W     = fre_pkg::ALPHA_W;
    localparam int     IVL_W       = fre_pkg::IVL_W;
    localparam int     CNT_W       = fre_pkg::CNT_W;
    localparam int     TS_W        = fre_pkg::TS_W;
    localparam int     CFG_IDX_W   = fre_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W  = fre_pkg::CFG_DATA_W;
    localparam int     FRAC        = fre_pkg::RATE_FRACTION_BITS_DEF;
    localparam longint RATE_TOP    = (longint'(1) << RATE_W) - 1;
    localparam longint FINE_TOP    = (RATE_TOP << FRAC) | ((longint'(1) << FRAC) - 1);
    localparam int     STALL_LIMIT = 5000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     REPORT_MAX  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    fre_pkg::sample_t      sample_bus = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    fre_pkg::result_t      result_bus;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // register copies used by the predictor
    logic signed [WEIGHT_W-1:0] tare_w      = fre_pkg::TARE_WEIGHT_RST;
    logic [ALPHA_W-1:0]         gain_rise   = fre_pkg::ALPHA_RISE_RST;
    logic [ALPHA_W-1:0]         gain_fall   = fre_pkg::ALPHA_FALL_RST;
    logic [RATE_W-1:0]          rate_floor  = fre_pkg::MIN_VALID_RATE_RST;
    logic [RATE_W-1:0]          rate_eps    = fre_pkg::ZERO_EPSILON_RST;
    logic [IVL_W-1:0]           ivl_min     = fre_pkg::MIN_INTERVAL_US_RST;
    logic [IVL_W-1:0]           ivl_max     = fre_pkg::MAX_INTERVAL_US_RST;
    logic [CNT_W-1:0]           no_flow_lim = fre_pkg::NO_FLOW_LIMIT_RST;

    // estimator state as the predictor sees it
    longint          last_rel    = 0;
    logic [TS_W-1:0] last_ts     = '0;
    logic            have_last   = 1'b0;
    int              no_flow_cnt = 0;
    logic [RATE_W-1:0] held_raw  = '0;
    longint          filt_fine   = 0;

    // pour generator position
    longint          pour_weight = 0;
    logic [TS_W-1:0] pour_ts     = '0;

    fre_pkg::result_t expected_rates[$];
    int      send_idle_pct = 29;
    int      recv_idle_pct = 68;
    int      mismatch_cnt  = 0;
    int      quiet_cycles  = 0;
    int      hold_req_cnt  = 0;
    int      hold_done_cnt = 0;
    int      hold_left     = 0;

    flow_rate_estimator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // one filter step, floor toward minus infinity, seeded when empty
    function automatic longint ewma_step(longint prev, longint target, logic [ALPHA_W-1:0] gain);
        longint prod;
        longint step;
        longint res;
        if (prev == 0)
            return target;
        prod = longint'(gain) * (target - prev);
        if (prod >= 0)
            step = prod / 256;
        else
            step = -((-prod + 255) / 256);
        res = prev + step;
        if (res < 0)
            res = 0;
        if (res > FINE_TOP)
            res = FINE_TOP;
        return res;
    endfunction

    // expected rates for one accepted beat, advancing the predictor state
    function automatic fre_pkg::result_t predict_rates(fre_pkg::sample_t s);
        longint           rel;
        longint           delta;
        longint           rate;
        longint unsigned  quot;
        logic [TS_W-1:0]  span;
        fre_pkg::result_t r;
        rel = longint'($signed(s.weight)) - longint'(tare_w);
        if (s.command == fre_pkg::CMD_RESTART)
        begin
            last_rel    = 0;
            last_ts     = '0;
            have_last   = 1'b0;
            no_flow_cnt = 0;
            held_raw    = '0;
            filt_fine   = 0;
            r = '0;
            return r;
        end
        if (have_last)
        begin
            span = s.timestamp_us - last_ts;
            if (span >= ivl_min && span <= ivl_max)
            begin
                delta = rel - last_rel;
                rate  = 0;
                if (delta > 0)
                begin
                    if (span == 0)
                        rate = RATE_TOP;
                    else
                    begin
                        quot = longint'(delta) * longint'(fre_pkg::US_PER_SEC) / span;
                        rate = (quot > RATE_TOP) ? RATE_TOP : longint'(quot);
                    end
                end
                if (rate < longint'(rate_floor))
                    rate = 0;
                held_raw = RATE_W'(rate);
                // no flow: count up, force zero at the limit, else decay
                if (rate == 0)
                begin
                    if (no_flow_cnt < int'(fre_pkg::NO_FLOW_SAT))
                        no_flow_cnt++;
                    if (no_flow_cnt >= int'(no_flow_lim))
                        filt_fine = 0;
                    else
                        filt_fine = ewma_step(filt_fine, 0, gain_fall);
                end
                else
                begin
                    no_flow_cnt = 0;
                    filt_fine = ewma_step(filt_fine, rate << FRAC,
                        ((rate << FRAC) >= filt_fine) ? gain_rise : gain_fall);
                end
                if (filt_fine < (longint'(rate_eps) << FRAC))
                    filt_fine = 0;
            end
        end
        last_rel  = rel;
        last_ts   = s.timestamp_us;
        have_last = 1'b1;
        r.raw_rate      = held_raw;
        r.filtered_rate = RATE_W'(filt_fine >> FRAC);
        return r;
    endfunction

    function automatic fre_pkg::sample_t make_item(logic cmd, longint w, logic [TS_W-1:0] ts);
        fre_pkg::sample_t s;
        s.command      = cmd;
        s.weight       = w[WEIGHT_W-1:0];
        s.timestamp_us = ts;
        return s;
    endfunction

    // next beat of a random pour: mostly in-window flow, some holds, noise, restarts
    function automatic fre_pkg::sample_t next_pour_item();
        int unsigned      roll;
        int unsigned      kind;
        longint unsigned  span;
        longint           step;
        fre_pkg::sample_t s;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return make_item(fre_pkg::CMD_RESTART, $urandom, $urandom);
        if (roll < 8)
        begin
            // noise: any weight, any spacing
            pour_weight = $urandom;
            span = $urandom;
        end
        else
        begin
            if (roll < 14)
            begin
                if ($urandom_range(0, 1) == 1 && ivl_min > 0)
                    span = $urandom_range(0, ivl_min - 1);
                else
                    span = longint'(ivl_max) + 1 + $urandom_range(0, 200000);
            end
            else
                span = $urandom_range(ivl_min, ivl_max);
            kind = $urandom_range(0, 99);
            if (kind < 60)
                step = longint'($urandom_range(0, 6000)) * longint'(span) / 1000000;
            else if (kind < 75)
                step = 0;
            else if (kind < 90)
                step = -longint'($urandom_range(0, 300));
            else
                step = $urandom_range(0, 2000000);
            pour_weight = pour_weight + step;
        end
        pour_ts = pour_ts + span[TS_W-1:0];
        s = make_item(fre_pkg::CMD_SAMPLE, pour_weight, pour_ts);
        pour_weight = longint'($signed(s.weight));
        return s;
    endfunction

    // offer one beat, with random idle cycles ahead of it
    task automatic send_sample(fre_pkg::sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_bus   <= s;
        do
            @(posedge clk);
        while (sample_stall);
        expected_rates.push_back(predict_rates(s));
    endtask

    // wait until every expected result has come back
    task automatic settle();
        sample_valid <= 1'b0;
        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fre_pkg::REG_TARE_WEIGHT:     tare_w      = value[WEIGHT_W-1:0];
            fre_pkg::REG_ALPHA_RISE:      gain_rise   = value[ALPHA_W-1:0];
            fre_pkg::REG_ALPHA_FALL:      gain_fall   = value[ALPHA_W-1:0];
            fre_pkg::REG_MIN_VALID_RATE:  rate_floor  = value[RATE_W-1:0];
            fre_pkg::REG_ZERO_EPSILON:    rate_eps    = value[RATE_W-1:0];
            fre_pkg::REG_MIN_INTERVAL_US: ivl_min     = value[IVL_W-1:0];
            fre_pkg::REG_MAX_INTERVAL_US: ivl_max     = value[IVL_W-1:0];
            fre_pkg::REG_NO_FLOW_LIMIT:   no_flow_lim = value[CNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // defaults: seeding, rise, fall, no-flow forcing, window edges, wrap
    task automatic test_directed();
        send_sample(make_item(fre_pkg::CMD_RESTART, $urandom, $urandom));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1000, 1000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1100, 101000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1250, 201000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1300, 301000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1290, 401000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1290, 501000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1300, 521000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1400, 1521000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1410, 1571000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 1411, 2371000));
        send_sample(make_item(fre_pkg::CMD_RESTART, 0, 0));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, -8388608, 32'hFFFF_0000));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 8388607, 34464));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 8388000, 134464));
        settle();
    endtask

    // register extremes: zero spacing, tare range ends, closed window
    task automatic test_reg_extremes();
        write_reg(fre_pkg::REG_TARE_WEIGHT, 32'h800000);
        write_reg(fre_pkg::REG_ALPHA_RISE, 255);
        write_reg(fre_pkg::REG_ALPHA_FALL, 0);
        write_reg(fre_pkg::REG_MIN_VALID_RATE, 0);
        write_reg(fre_pkg::REG_ZERO_EPSILON, 0);
        write_reg(fre_pkg::REG_MIN_INTERVAL_US, 0);
        write_reg(fre_pkg::REG_MAX_INTERVAL_US, 32'hFFFFFF);
        write_reg(fre_pkg::REG_NO_FLOW_LIMIT, 255);
        send_sample(make_item(fre_pkg::CMD_RESTART, -1, 32'hFFFF_FFFF));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 8388607, 5));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 8388607, 5));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, -8388608, 5));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, -8388000, 5));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, -8387900, 16777220));
        settle();

        write_reg(fre_pkg::REG_TARE_WEIGHT, 32'h7FFFFF);
        write_reg(fre_pkg::REG_ALPHA_RISE, 0);
        write_reg(fre_pkg::REG_ALPHA_FALL, 255);
        write_reg(fre_pkg::REG_MIN_VALID_RATE, 32'hFFFFF);
        write_reg(fre_pkg::REG_ZERO_EPSILON, 32'hFFFFF);
        write_reg(fre_pkg::REG_MIN_INTERVAL_US, 32'hFFFFFF);
        write_reg(fre_pkg::REG_NO_FLOW_LIMIT, 1);
        send_sample(make_item(fre_pkg::CMD_RESTART, 0, 0));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, -8388608, 0));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 8388607, 16777215));
        settle();

        // window closed: minimum above maximum
        write_reg(fre_pkg::REG_MIN_INTERVAL_US, 1000);
        write_reg(fre_pkg::REG_MAX_INTERVAL_US, 999);
        write_reg(fre_pkg::REG_MIN_VALID_RATE, 0);
        write_reg(fre_pkg::REG_ZERO_EPSILON, 0);
        send_sample(make_item(fre_pkg::CMD_RESTART, 0, 0));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 0, 0));
        send_sample(make_item(fre_pkg::CMD_SAMPLE, 500, 1000));
        settle();
    endtask

    task automatic load_random_setup();
        int unsigned lo;
        int unsigned hi;
        lo = $urandom_range(0, 120000);
        hi = lo + $urandom_range(0, 900000);
        write_reg(fre_pkg::REG_TARE_WEIGHT, $urandom);
        write_reg(fre_pkg::REG_ALPHA_RISE, $urandom_range(0, 255));
        write_reg(fre_pkg::REG_ALPHA_FALL, $urandom_range(0, 255));
        write_reg(fre_pkg::REG_MIN_VALID_RATE, $urandom_range(0, 1500));
        write_reg(fre_pkg::REG_ZERO_EPSILON, $urandom_range(0, 400));
        write_reg(fre_pkg::REG_MIN_INTERVAL_US, lo);
        write_reg(fre_pkg::REG_MAX_INTERVAL_US, hi);
        if ($urandom_range(0, 3) == 0)
            write_reg(fre_pkg::REG_NO_FLOW_LIMIT, $urandom_range(1, 255));
        else
            write_reg(fre_pkg::REG_NO_FLOW_LIMIT, $urandom_range(1, 6));
    endtask

    task automatic test_random_pours(int count);
        load_random_setup();
        pour_ts     = $urandom;
        pour_weight = $urandom_range(0, 100000);
        repeat (count) send_sample(next_pour_item());
        settle();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_result_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req_cnt++;
        repeat (24) send_sample(next_pour_item());
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_reg_extremes();
        test_random_pours(334);
        send_idle_pct = 68;
        recv_idle_pct = 29;
        test_random_pours(333);
        test_result_holdoff();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pours(310);

        settle();
        repeat (40) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // result checking and receiver stall
    always @(posedge clk)
    begin : rate_check
        fre_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_rates.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result beat: raw_rate %0d filtered_rate %0d",
                             result_bus.raw_rate, result_bus.filtered_rate);
            end
            else
            begin
                want = expected_rates.pop_front();
                if (result_bus.raw_rate !== want.raw_rate ||
                    result_bus.filtered_rate !== want.filtered_rate)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("rate mismatch: raw exp %0d got %0d, filt exp %0d got %0d",
                                 want.raw_rate, result_bus.raw_rate,
                                 want.filtered_rate, result_bus.filtered_rate);
                end
            end
        end
        if (hold_req_cnt != hold_done_cnt)
        begin
            hold_done_cnt = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

endmodule
